// File: rtl/rkc_pkg.sv
package rkc_pkg;

   // Pixel and coefficient formats
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 11;
   localparam int KERNEL    = 3;
   localparam int TAPS      = 3;

   // Configuration port
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;

   // Position counters
   localparam int OUT_ROW_W = 12;
   localparam int IN_ROW_W  = 13;

   // Accumulation widths: 8b x 16b product, sum of three, sum of nine
   localparam int PROD_W = 24;
   localparam int RSUM_W = 26;
   localparam int SUM_W  = 28;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CNT_W = 4;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

   localparam int WIDTH_RESET = 1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_M1_RESET = 12'd479;
   localparam logic [CSR_DATA_W-1:0] COEF_TOP_RESET    = 48'd0;
   localparam logic [CSR_DATA_W-1:0] COEF_MID_RESET    = 48'd2048;
   localparam logic [CSR_DATA_W-1:0] COEF_BOTTOM_RESET = 48'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_COEF_TOP     = 3'd2,
      CSR_COEF_MID     = 3'd3,
      CSR_COEF_BOTTOM  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // One line memory word: the same column of the two previous rows
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_type;

   // Which neighbors of the centre lie inside the frame
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   typedef struct packed {
      logic       valid;
      logic       produce;
      logic       last;
      border_type border;
   } step_type;

   typedef pixel_type [TAPS-1:0] column_type;
   typedef pixel_type [TAPS-1:0][TAPS-1:0] tap_set_type;
   typedef logic [KERNEL-1:0][CSR_DATA_W-1:0] coef_set_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } result_type;

endpackage

// File: rtl/rkc_line_mem.sv
module rkc_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Single write port, registered read (read before write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rkc_ctrl.sv
module rkc_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rkc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rkc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_command,
   output logic                            req_ready,
   input  logic                            rsp_fire,
   output rkc_pkg::step_type               step,
   output logic [$clog2(MAX_WIDTH)-1:0]    col,
   output rkc_pkg::coef_set_type           coef
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WX = (COL_W + 1 > rkc_pkg::WIDTH_REG_W) ? COL_W + 1 : rkc_pkg::WIDTH_REG_W;
   localparam int W_RESET = (rkc_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : rkc_pkg::WIDTH_RESET;
   localparam logic [COL_W-1:0] W_M1_RESET = COL_W'(W_RESET - 1);

   logic [COL_W-1:0]                     w_m1_ff, w_m1_in;
   logic [rkc_pkg::HEIGHT_REG_W-1:0]     h_m1_ff, h_m1_in;
   rkc_pkg::coef_set_type                coef_ff, coef_in;
   logic [COL_W-1:0]                     in_col_ff, in_col_in;
   logic [rkc_pkg::IN_ROW_W-1:0]         in_row_ff, in_row_in;
   logic [COL_W-1:0]                     out_col_ff, out_col_in;
   logic [rkc_pkg::OUT_ROW_W-1:0]        out_row_ff, out_row_in;
   logic [rkc_pkg::FIFO_CNT_W-1:0]       pend_cnt_ff, pend_cnt_in;

   logic                                 accept, in_frame, ignore, take, early, produce, at_last;
   logic                                 restart;
   logic [WX-1:0]                        w_ext;
   logic [rkc_pkg::HEIGHT_REG_W-1:0]     h_raw;

   // Frame position decode
   always_comb begin
      accept   = req_valid && req_ready;
      in_frame = in_row_ff <= {1'b0, h_m1_ff};
      ignore   = in_frame && req_command;
      take     = accept && !ignore;
      early    = (in_row_ff == '0) ||
                 ((in_row_ff == rkc_pkg::IN_ROW_W'(1)) && (in_col_ff == '0));
      produce  = !early;
      at_last  = (out_row_ff == h_m1_ff) && (out_col_ff == w_m1_ff);
   end

   // Configuration and position counters
   always_comb begin
      w_m1_in    = w_m1_ff;
      h_m1_in    = h_m1_ff;
      coef_in    = coef_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      restart    = 1'b0;
      w_ext      = WX'(csr_write_data[rkc_pkg::WIDTH_REG_W-1:0]);
      h_raw      = csr_write_data[rkc_pkg::HEIGHT_REG_W-1:0];

      if (csr_write_enable) begin
         case (csr_index)
            rkc_pkg::CSR_IMAGE_WIDTH: begin
               if (w_ext == '0) begin
                  w_m1_in = '0;
               end else if (w_ext > WX'(MAX_WIDTH)) begin
                  w_m1_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  w_m1_in = COL_W'(w_ext - WX'(1));
               end
               restart = 1'b1;
            end
            rkc_pkg::CSR_IMAGE_HEIGHT: begin
               h_m1_in = (h_raw == '0) ? '0 : h_raw - rkc_pkg::HEIGHT_REG_W'(1);
               restart = 1'b1;
            end
            rkc_pkg::CSR_COEF_TOP:    coef_in[0] = csr_write_data;
            rkc_pkg::CSR_COEF_MID:    coef_in[1] = csr_write_data;
            rkc_pkg::CSR_COEF_BOTTOM: coef_in[2] = csr_write_data;
            default: ;
         endcase
      end

      if (restart || (take && produce && at_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (in_col_ff == w_m1_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + rkc_pkg::IN_ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (produce) begin
            if (out_col_ff == w_m1_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + rkc_pkg::OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // Results owed: in the pipeline or waiting in the queue
   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      if (take && produce && !rsp_fire) begin
         pend_cnt_in = pend_cnt_ff + rkc_pkg::FIFO_CNT_W'(1);
      end else if (!(take && produce) && rsp_fire) begin
         pend_cnt_in = pend_cnt_ff - rkc_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff     <= W_M1_RESET;
         h_m1_ff     <= rkc_pkg::HEIGHT_M1_RESET;
         coef_ff[0]  <= rkc_pkg::COEF_TOP_RESET;
         coef_ff[1]  <= rkc_pkg::COEF_MID_RESET;
         coef_ff[2]  <= rkc_pkg::COEF_BOTTOM_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pend_cnt_ff <= '0;
      end else begin
         w_m1_ff     <= w_m1_in;
         h_m1_ff     <= h_m1_in;
         coef_ff     <= coef_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   // Step descriptor for the line memory stage
   always_comb begin
      req_ready            = pend_cnt_ff < rkc_pkg::FIFO_CNT_W'(rkc_pkg::FIFO_DEPTH);
      step.valid           = take;
      step.produce         = produce;
      step.last            = produce && at_last;
      step.border.top      = out_row_ff != '0;
      step.border.bottom   = out_row_ff != h_m1_ff;
      step.border.left     = out_col_ff != '0;
      step.border.right    = out_col_ff != w_m1_ff;
      col                  = in_col_ff;
      coef                 = coef_ff;
   end

`ifndef SYNTHESIS
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= rkc_pkg::FIFO_CNT_W'(rkc_pkg::FIFO_DEPTH))
      else $error("owed result count exceeds queue depth");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (take && produce && at_last) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("frame did not restart after its last pixel");
`endif

endmodule

// File: rtl/rkc_window.sv
module rkc_window #(
   parameter int COL_W = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rkc_pkg::step_type      step_in,
   input  logic [COL_W-1:0]       col_in,
   input  rkc_pkg::pixel_type     pix_in,
   input  rkc_pkg::line_type      rd_data,
   output logic                   wr_en,
   output logic [COL_W-1:0]       wr_addr,
   output rkc_pkg::line_type      wr_data,
   output logic                   tap_valid,
   output logic                   tap_last,
   output rkc_pkg::tap_set_type   taps
);

   rkc_pkg::step_type     s1_step_ff;
   logic [COL_W-1:0]      s1_col_ff;
   rkc_pkg::pixel_type    s1_pix_ff;
   logic                  fwd_hit_ff, fwd_hit_in;
   rkc_pkg::line_type     fwd_data_ff;
   rkc_pkg::column_type   hist1_ff, hist2_ff;
   rkc_pkg::tap_set_type  taps_ff, taps_in;
   logic                  tap_valid_ff, tap_last_ff;

   rkc_pkg::line_type     line;
   rkc_pkg::column_type   column;
   rkc_pkg::pixel_type    src;
   logic                  keep;

   // Line word with bypass of last cycle's write to the same column
   always_comb begin
      line       = fwd_hit_ff ? fwd_data_ff : rd_data;
      column[0]  = line.older;
      column[1]  = line.newer;
      column[2]  = s1_pix_ff;
      wr_en      = s1_step_ff.valid;
      wr_addr    = s1_col_ff;
      wr_data.older = line.newer;
      wr_data.newer = s1_pix_ff;
      fwd_hit_in = step_in.valid && s1_step_ff.valid && (col_in == s1_col_ff);
   end

   // 3x3 window, out-of-frame neighbors forced to zero
   always_comb begin
      src  = '0;
      keep = 1'b0;
      for (int a = 0; a < rkc_pkg::TAPS; a++) begin
         for (int b = 0; b < rkc_pkg::TAPS; b++) begin
            if (b == 0) begin
               src = hist2_ff[a];
            end else if (b == 1) begin
               src = hist1_ff[a];
            end else begin
               src = column[a];
            end
            keep = (a != 0 || s1_step_ff.border.top) &&
                   (a != rkc_pkg::TAPS - 1 || s1_step_ff.border.bottom) &&
                   (b != 0 || s1_step_ff.border.left) &&
                   (b != rkc_pkg::TAPS - 1 || s1_step_ff.border.right);
            taps_in[a][b] = keep ? src : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_step_ff   <= '0;
         tap_valid_ff <= 1'b0;
      end else begin
         s1_step_ff   <= step_in;
         tap_valid_ff <= s1_step_ff.valid && s1_step_ff.produce;
      end
   end

   always_ff @(posedge clock) begin
      if (step_in.valid) begin
         s1_col_ff   <= col_in;
         s1_pix_ff   <= pix_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= wr_data;
      end
      if (s1_step_ff.valid) begin
         hist2_ff    <= hist1_ff;
         hist1_ff    <= column;
         taps_ff     <= taps_in;
         tap_last_ff <= s1_step_ff.last;
      end
   end

   assign tap_valid = tap_valid_ff;
   assign tap_last  = tap_last_ff;
   assign taps      = taps_ff;

`ifndef SYNTHESIS
   a_fwd_match: assert property (@(posedge clock) disable iff (reset)
      (s1_step_ff.valid && fwd_hit_ff) |-> ($past(wr_en) && $past(wr_addr) == s1_col_ff))
      else $error("line bypass taken without a write to that column");
`endif

endmodule

// File: rtl/rkc_filter.sv
module rkc_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tap_valid,
   input  logic                   tap_last,
   input  rkc_pkg::tap_set_type   taps,
   input  rkc_pkg::coef_set_type  coef,
   output logic                   res_valid,
   output rkc_pkg::result_type    res
);

   localparam int CH = 3;
   localparam int T  = rkc_pkg::TAPS;

   logic signed [rkc_pkg::PROD_W-1:0] prod_ff [CH][T][T];
   logic signed [rkc_pkg::PROD_W-1:0] prod_in [CH][T][T];
   logic signed [rkc_pkg::RSUM_W-1:0] rsum_ff [CH][T];
   logic signed [rkc_pkg::RSUM_W-1:0] rsum_in [CH][T];
   logic signed [rkc_pkg::SUM_W-1:0]  total   [CH];
   logic                              v3_ff, v4_ff, last3_ff, last4_ff;

   function automatic logic [rkc_pkg::PIX_W-1:0] clamp_sum(
      input logic signed [rkc_pkg::SUM_W-1:0] s);
      logic [rkc_pkg::SUM_W-1:0] shifted;
      shifted = $unsigned(s) >> rkc_pkg::COEF_FRAC;
      if (s[rkc_pkg::SUM_W-1]) begin
         return rkc_pkg::PIX_MIN;
      end else if (shifted > rkc_pkg::SUM_W'(rkc_pkg::PIX_MAX)) begin
         return rkc_pkg::PIX_MAX;
      end
      return shifted[rkc_pkg::PIX_W-1:0];
   endfunction

   function automatic logic [rkc_pkg::PIX_W-1:0] chan(input rkc_pkg::pixel_type p,
                                                      input int c);
      logic [rkc_pkg::PIX_W-1:0] v;
      case (c)
         0:       v = p.red;
         1:       v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

   // Stage 1: 27 parallel pixel x coefficient products
   always_comb begin
      int fi, fj;
      logic [rkc_pkg::COEF_W-1:0]        coef_v;
      logic signed [rkc_pkg::PROD_W-1:0] coef_ext, pix_ext;
      for (int a = 0; a < T; a++) begin
         for (int b = 0; b < T; b++) begin
            fi = a - 1 + rkc_pkg::KERNEL / 2;
            fj = b - 1 + rkc_pkg::KERNEL / 2;
            coef_v = '0;
            if (fi >= 0 && fi < rkc_pkg::KERNEL && fj >= 0 && fj < rkc_pkg::KERNEL) begin
               coef_v = coef[fi][rkc_pkg::COEF_W*fj +: rkc_pkg::COEF_W];
            end
            coef_ext = {{(rkc_pkg::PROD_W - rkc_pkg::COEF_W){coef_v[rkc_pkg::COEF_W-1]}},
                        coef_v};
            for (int c = 0; c < CH; c++) begin
               pix_ext = {{(rkc_pkg::PROD_W - rkc_pkg::PIX_W){1'b0}}, chan(taps[a][b], c)};
               prod_in[c][a][b] = pix_ext * coef_ext;
            end
         end
      end
   end

   // Stage 2: sum each kernel row
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         for (int a = 0; a < T; a++) begin
            rsum_in[c][a] = rkc_pkg::RSUM_W'(prod_ff[c][a][0]) +
                            rkc_pkg::RSUM_W'(prod_ff[c][a][1]) +
                            rkc_pkg::RSUM_W'(prod_ff[c][a][2]);
         end
      end
   end

   // Stage 3: total, floor and clamp
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         total[c] = rkc_pkg::SUM_W'(rsum_ff[c][0]) +
                    rkc_pkg::SUM_W'(rsum_ff[c][1]) +
                    rkc_pkg::SUM_W'(rsum_ff[c][2]);
      end
      res.pix.red   = clamp_sum(total[0]);
      res.pix.green = clamp_sum(total[1]);
      res.pix.blue  = clamp_sum(total[2]);
      res.last      = last4_ff;
      res_valid     = v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= tap_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_valid) begin
         prod_ff  <= prod_in;
         last3_ff <= tap_last;
      end
      if (v3_ff) begin
         rsum_ff  <= rsum_in;
         last4_ff <= last3_ff;
      end
   end

endmodule

// File: rtl/rkc_out_fifo.sv
module rkc_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rkc_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 out_valid,
   output rkc_pkg::result_type  out_data
);

   rkc_pkg::result_type                store_ff [rkc_pkg::FIFO_DEPTH];
   logic [rkc_pkg::FIFO_AW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [rkc_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                               pop_ok;

   always_comb begin
      out_valid = count_ff != '0;
      out_data  = store_ff[rd_ptr_ff];
      pop_ok    = pop && out_valid;
      count_in  = count_ff;
      if (push && !pop_ok) begin
         count_in = count_ff + rkc_pkg::FIFO_CNT_W'(1);
      end else if (!push && pop_ok) begin
         count_in = count_ff - rkc_pkg::FIFO_CNT_W'(1);
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rkc_pkg::FIFO_AW'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + rkc_pkg::FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != rkc_pkg::FIFO_CNT_W'(rkc_pkg::FIFO_DEPTH)))
      else $error("result queue written while full");
`endif

endmodule

// File: rtl/rgb_kernel_convolution_unit.sv
// 3x3 RGB convolution over a raster-order pixel stream with zero padding at the
// frame border. One item is taken per clock unless the input stalls; the result
// for centre pixel n is produced by the item at raster index n + width + 1 and
// passes the window, product and row-sum registers into the output queue. The
// rate is set by the line memory, which is read and written once per item at
// the item's column (a back-to-back hit on the same column is bypassed),
// followed by a multiply, row-sum and total/clamp pipeline. Up to 8 results
// may be owed at once; the input stalls only when that many are pending. After
// the last frame pixel, send width + 1 drain items (command = 1) to flush the
// final row; a drain item sent before the frame is complete is accepted and
// discarded. Writing image_width or image_height restarts the frame; coefficient
// writes apply at once. Configure only while idle. The line memory needs no
// clearing after reset: out-of-frame taps are masked.
module rgb_kernel_convolution_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rkc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rkc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [rkc_pkg::PIX_W-1:0]       req_red_in,
   input  logic [rkc_pkg::PIX_W-1:0]       req_green_in,
   input  logic [rkc_pkg::PIX_W-1:0]       req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rkc_pkg::PIX_W-1:0]       rsp_red_out,
   output logic [rkc_pkg::PIX_W-1:0]       rsp_green_out,
   output logic [rkc_pkg::PIX_W-1:0]       rsp_blue_out,
   output logic                            rsp_frame_end
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LINE_W = $bits(rkc_pkg::line_type);

   rkc_pkg::step_type      step;
   logic [COL_W-1:0]       col;
   rkc_pkg::coef_set_type  coef;
   rkc_pkg::pixel_type     pix_in;
   logic [LINE_W-1:0]      mem_rd_data;
   rkc_pkg::line_type      rd_line;
   logic                   wr_en;
   logic [COL_W-1:0]       wr_addr;
   rkc_pkg::line_type      wr_line;
   logic                   tap_valid, tap_last;
   rkc_pkg::tap_set_type   taps;
   logic                   res_valid;
   rkc_pkg::result_type    res;
   rkc_pkg::result_type    out_data;
   logic                   rsp_fire;

   assign pix_in.red   = req_red_in;
   assign pix_in.green = req_green_in;
   assign pix_in.blue  = req_blue_in;
   assign rd_line      = mem_rd_data;
   assign rsp_fire     = rsp_valid && rsp_ready;

   // Position tracking, configuration and flow control
   rkc_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_command      (req_command),
      .req_ready        (req_ready),
      .rsp_fire         (rsp_fire),
      .step             (step),
      .col              (col),
      .coef             (coef)
   );

   // Two previous rows, one word per column
   rkc_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W),
      .DW    (LINE_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (step.valid),
      .rd_addr (col),
      .rd_data (mem_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_line)
   );

   // Line update and window gathering
   rkc_window #(
      .COL_W (COL_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step_in   (step),
      .col_in    (col),
      .pix_in    (pix_in),
      .rd_data   (rd_line),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_line),
      .tap_valid (tap_valid),
      .tap_last  (tap_last),
      .taps      (taps)
   );

   // Multiply-accumulate and clamp
   rkc_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .tap_valid (tap_valid),
      .tap_last  (tap_last),
      .taps      (taps),
      .coef      (coef),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result queue decouples the output handshake
   rkc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_red_out   = out_data.pix.red;
   assign rsp_green_out = out_data.pix.green;
   assign rsp_blue_out  = out_data.pix.blue;
   assign rsp_frame_end = out_data.last;

endmodule
